// ----- design/wlpa_pkg.sv -----
// Shared types and constants for the wave loop playback addresser.
// No dependencies; every design file refers to it by scoped names.
`default_nettype none

package wlpa_pkg;

    localparam int INDEX_W  = 12;
    localparam int LEN_W    = 13;
    localparam int SAMPLE_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_BEGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED        = 3'd5;

    typedef struct packed {
        logic                bounce;
        logic                loop_en;
        logic [INDEX_W-1:0]  loop_begin;
        logic [INDEX_W-1:0]  last_index;
        logic [LEN_W-1:0]    stored_length;
        logic [SAMPLE_W-1:0] seed;
    } t_cfg;

    // Item in flight between the sequencer and the output stage
    typedef struct packed {
        logic               restart;
        logic               integrate;
        logic               take_mem;
        logic               finished;
        logic [INDEX_W-1:0] index;
    } t_s1;

endpackage

`default_nettype wire

// ----- design/wlpa_store.sv -----
// Sample store: one write and one registered read per cycle.
// Uses wlpa_pkg for the word width.
`default_nettype none

module wlpa_store #(
    parameter int MAX_SAMPLES = 4096,
    localparam int AW = $clog2(MAX_SAMPLES)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [AW-1:0]                 i_wr_addr,
    input  wire logic [wlpa_pkg::SAMPLE_W-1:0] i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [AW-1:0]                 i_rd_addr,
    output logic      [wlpa_pkg::SAMPLE_W-1:0] o_rd_data
);

    logic [wlpa_pkg::SAMPLE_W-1:0] r_mem [MAX_SAMPLES];
    logic [wlpa_pkg::SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- design/wlpa_sequencer.sv -----
// Play position sequencer: forward stepping and the three-leg ping-pong walk.
// Issues the store read and fills the stage register; uses wlpa_pkg.
`default_nettype none

module wlpa_sequencer #(
    parameter int MAX_SAMPLES = 4096,
    localparam int AW    = $clog2(MAX_SAMPLES),
    localparam int POS_W = $clog2(MAX_SAMPLES + 2)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire wlpa_pkg::t_cfg       i_cfg,
    input  wire logic                 i_accept,
    input  wire logic [1:0]           i_opcode,
    input  wire logic                 i_out_en,
    output logic                      o_ready,
    output logic                      o_s1_valid,
    output wlpa_pkg::t_s1             o_s1,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_rd_addr
);

    localparam int CW = (POS_W > wlpa_pkg::LEN_W) ? POS_W : wlpa_pkg::LEN_W;
    localparam int PX = (POS_W > wlpa_pkg::INDEX_W) ? POS_W : wlpa_pkg::INDEX_W;

    typedef enum logic [2:0] {
        LEG_LEAD = 3'b001,
        LEG_DOWN = 3'b010,
        LEG_UP   = 3'b100
    } t_leg;

    logic [POS_W-1:0] r_pos, n_pos;
    t_leg             r_leg, n_leg;
    logic             r_ended, n_ended;
    logic             r_s1_valid, n_s1_valid;
    wlpa_pkg::t_s1    r_s1, n_s1;

    logic [CW-1:0] cur_c, lo_c, hi_c, max_c, sl_c, len_c, inc_c;
    logic [PX-1:0] cur_x;

    always_comb begin
        cur_c = CW'(r_pos);
        lo_c  = CW'(i_cfg.loop_begin);
        hi_c  = CW'(i_cfg.last_index);
        max_c = CW'(MAX_SAMPLES);
        sl_c  = CW'(i_cfg.stored_length);
        len_c = (sl_c < max_c) ? sl_c : max_c;
        inc_c = cur_c + CW'(1);
        cur_x = PX'(r_pos);
    end

    assign o_ready = !r_s1_valid || i_out_en;

    always_comb begin
        n_pos      = r_pos;
        n_leg      = r_leg;
        n_ended    = r_ended;
        n_s1       = r_s1;
        n_s1_valid = r_s1_valid && !i_out_en;
        if (i_accept) begin
            n_s1_valid = 1'b0;
            n_s1       = '0;
            unique case (wlpa_pkg::t_opcode'(i_opcode))
                wlpa_pkg::OP_ADVANCE: begin
                    n_s1_valid = 1'b1;
                    if (i_cfg.bounce) begin
                        if (r_ended) begin
                            n_s1.finished = 1'b1;
                        end else begin
                            n_s1.integrate = 1'b1;
                            n_s1.take_mem  = cur_c < max_c;
                            n_s1.index     = cur_x[wlpa_pkg::INDEX_W-1:0];
                            unique case (r_leg)
                                LEG_LEAD: begin
                                    if (cur_c >= hi_c) begin
                                        if (hi_c <= lo_c) begin
                                            n_ended = 1'b1;
                                            n_pos   = POS_W'(inc_c);
                                        end else begin
                                            n_leg = LEG_DOWN;
                                            n_pos = POS_W'(hi_c);
                                        end
                                    end else begin
                                        n_pos = POS_W'(inc_c);
                                    end
                                end
                                LEG_DOWN: begin
                                    if (cur_c <= lo_c) begin
                                        n_leg = LEG_UP;
                                        n_pos = POS_W'(lo_c);
                                    end else begin
                                        n_pos = POS_W'(cur_c - CW'(1));
                                    end
                                end
                                default: begin
                                    if (cur_c >= hi_c) begin
                                        n_leg = LEG_DOWN;
                                        n_pos = POS_W'(hi_c);
                                    end else begin
                                        n_pos = POS_W'(inc_c);
                                    end
                                end
                            endcase
                        end
                    end else begin
                        if (cur_c < len_c) begin
                            n_s1.take_mem = 1'b1;
                            n_s1.index    = cur_x[wlpa_pkg::INDEX_W-1:0];
                        end else begin
                            n_s1.finished = !i_cfg.loop_en;
                        end
                        if (i_cfg.loop_en && cur_c >= hi_c) begin
                            n_pos = POS_W'(lo_c);
                        end else if (cur_c < max_c) begin
                            n_pos = POS_W'(inc_c);
                        end else begin
                            n_pos = POS_W'(max_c);
                        end
                    end
                end
                wlpa_pkg::OP_RESTART: begin
                    n_s1_valid   = 1'b1;
                    n_s1.restart = 1'b1;
                    n_pos        = '0;
                    n_leg        = LEG_LEAD;
                    n_ended      = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_leg      <= LEG_LEAD;
            r_ended    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_leg      <= n_leg;
            r_ended    <= n_ended;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
    assign o_rd_en    = i_accept && (i_opcode == wlpa_pkg::OP_ADVANCE);
    assign o_rd_addr  = r_pos[AW-1:0];

endmodule

`default_nettype wire

// ----- design/wlpa_output.sv -----
// Output stage: predictor integration and the result register.
// Takes the stage register from wlpa_sequencer and store data; uses wlpa_pkg.
`default_nettype none

module wlpa_output (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [wlpa_pkg::SAMPLE_W-1:0] i_seed,
    input  wire logic                          i_s1_valid,
    input  wire wlpa_pkg::t_s1                 i_s1,
    input  wire logic [wlpa_pkg::SAMPLE_W-1:0] i_rd_data,
    input  wire logic                          i_out_ready,
    output logic                               o_out_en,
    output logic                               o_valid,
    output logic      [wlpa_pkg::SAMPLE_W-1:0] o_sample,
    output logic      [wlpa_pkg::INDEX_W-1:0]  o_index,
    output logic                               o_finished
);

    logic                          r_valid;
    logic [wlpa_pkg::SAMPLE_W-1:0] r_pred;
    logic [wlpa_pkg::SAMPLE_W-1:0] r_sample;
    logic [wlpa_pkg::INDEX_W-1:0]  r_index;
    logic                          r_finished;

    logic                          out_en, move, emit;
    logic [wlpa_pkg::SAMPLE_W-1:0] word, sum;

    always_comb begin
        out_en = !r_valid || i_out_ready;
        move   = i_s1_valid && out_en;
        emit   = move && !i_s1.restart;
        word   = i_s1.take_mem ? i_rd_data : '0;
        sum    = r_pred + word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pred  <= '0;
        end else begin
            if (out_en) begin
                r_valid <= emit;
            end
            if (move) begin
                if (i_s1.restart) begin
                    r_pred <= i_seed;
                end else if (i_s1.integrate) begin
                    r_pred <= sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_sample   <= i_s1.integrate ? sum : word;
            r_index    <= i_s1.index;
            r_finished <= i_s1.finished;
        end
    end

    assign o_out_en   = out_en;
    assign o_valid    = r_valid;
    assign o_sample   = r_sample;
    assign o_index    = r_index;
    assign o_finished = r_finished;

endmodule

`default_nettype wire

// ----- design/wave_loop_playback_addresser_top.sv -----
// Top level of the wave loop playback addresser: configuration registers,
// stream ports and the store, sequencer and output stage. Uses wlpa_pkg.
//
// Write transactions fill the sample store, advance transactions play it out
// (forward with optional loop, or ping-pong walk integrating deltas into a
// predictor), restart transactions rewind and reload the predictor seed.
// One transaction of any kind is accepted every cycle while the output side
// keeps up; accepting an advance registers the store read and the stage
// register, and the output register is loaded from them once the output side
// has room.
// Only advance transactions produce results. Store entries never written
// read as unknown data.
`default_nettype none

module wave_loop_playback_addresser_top #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [wlpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [wlpa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [11:0] store_address, [43:12] store_word, [47:44] zero
    input  wire logic [wlpa_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [31:0] sample_out, [43:32] read_index, [47:44] zero
    output logic      [wlpa_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // [0] finished
    output logic                                   m_axis_tuser
);

    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int AW_X = (AW > wlpa_pkg::INDEX_W) ? AW : wlpa_pkg::INDEX_W;

    wlpa_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wlpa_pkg::CFG_BOUNCE_MODE: r_cfg.bounce        <= i_cfg_data[0];
                wlpa_pkg::CFG_LOOP_ENABLE: r_cfg.loop_en       <= i_cfg_data[0];
                wlpa_pkg::CFG_LOOP_BEGIN:  r_cfg.loop_begin    <= i_cfg_data[11:0];
                wlpa_pkg::CFG_LAST_INDEX:  r_cfg.last_index    <= i_cfg_data[11:0];
                wlpa_pkg::CFG_STORED_LEN:  r_cfg.stored_length <= i_cfg_data[12:0];
                wlpa_pkg::CFG_SEED:        r_cfg.seed          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                          accept, ready, out_en, wr_en, rd_en, s1_valid;
    logic [AW_X-1:0]               addr_x;
    logic [AW-1:0]                 rd_addr;
    logic [wlpa_pkg::SAMPLE_W-1:0] rd_data, sample;
    logic [wlpa_pkg::INDEX_W-1:0]  index;
    logic                          finished;
    wlpa_pkg::t_s1                 s1;

    always_comb begin
        accept = s_axis_tvalid && ready;
        addr_x = AW_X'(s_axis_tdata[11:0]);
        wr_en  = accept && (s_axis_tuser == wlpa_pkg::OP_WRITE)
                 && ({1'b0, addr_x} < (AW_X+1)'(MAX_SAMPLES));
    end

    wlpa_store #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (addr_x[AW-1:0]),
        .i_wr_data (s_axis_tdata[43:12]),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    wlpa_sequencer #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_sequencer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (accept),
        .i_opcode   (s_axis_tuser),
        .i_out_en   (out_en),
        .o_ready    (ready),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr)
    );

    wlpa_output u_output (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed      (r_cfg.seed),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_rd_data   (rd_data),
        .i_out_ready (m_axis_tready),
        .o_out_en    (out_en),
        .o_valid     (m_axis_tvalid),
        .o_sample    (sample),
        .o_index     (index),
        .o_finished  (finished)
    );

    assign s_axis_tready = ready;
    assign m_axis_tdata  = {4'b0000, index, sample};
    assign m_axis_tuser  = finished;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for wave_loop_playback_addresser_top: forward and ping-pong playback
// checked against an in-bench predictor, with random stalls on both streams.
// Depends on wlpa_pkg and the design top only.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W   = wlpa_pkg::SAMPLE_W;
    localparam int INDEX_W    = wlpa_pkg::INDEX_W;
    localparam int LEN_W      = wlpa_pkg::LEN_W;
    localparam int CFG_IDX_W  = wlpa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = wlpa_pkg::CFG_DATA_W;
    localparam int S_TDATA_W  = wlpa_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = wlpa_pkg::M_TDATA_W;

    localparam int MAX_SAMPLES = 4096;
    // low part of the store that gets written; the top entry is written too
    localparam int FILL_N      = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] LEG_LEAD_IN = 2'd0;
    localparam logic [1:0] LEG_DOWN    = 2'd1;
    localparam logic [1:0] LEG_UP      = 2'd2;
    localparam logic [5:0] ALL_REGS    = 6'b111111;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]  index;
        logic                finished;
    } t_play_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;

    // predictor state
    logic [SAMPLE_W-1:0] store_mem [MAX_SAMPLES];
    logic [LEN_W-1:0]    play_pos;
    logic [1:0]          leg;
    logic                walk_done;
    logic [SAMPLE_W-1:0] accum;
    wlpa_pkg::t_cfg      mdl_cfg;
    t_play_result        sample_q[$];

    bit steady = 1'b0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int checked_count = 0;
    int accepted_count = 0;
    int walk_count = 0;
    int reg_update_count = 0;

    wave_loop_playback_addresser_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     sample_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 11);
    end

    // One advance step of the playback engine; updates the predictor state.
    function automatic t_play_result play_step();
        t_play_result r;
        int pos, nxt, lo, hi, len;
        r = '0;
        pos = int'(play_pos);
        lo = int'(mdl_cfg.loop_begin);
        hi = int'(mdl_cfg.last_index);
        if (!mdl_cfg.bounce) begin
            len = (int'(mdl_cfg.stored_length) < MAX_SAMPLES) ?
                  int'(mdl_cfg.stored_length) : MAX_SAMPLES;
            if (pos < len) begin
                r.sample = store_mem[pos];
                r.index = pos[INDEX_W-1:0];
            end else begin
                r.finished = !mdl_cfg.loop_en;
            end
            if (mdl_cfg.loop_en && pos + 1 > hi) begin
                play_pos = LEN_W'(lo);
            end else if (pos < MAX_SAMPLES) begin
                play_pos = LEN_W'(pos + 1);
            end else begin
                play_pos = LEN_W'(MAX_SAMPLES);
            end
        end else if (walk_done) begin
            r.finished = 1'b1;
        end else begin
            nxt = pos;
            case (leg)
                LEG_LEAD_IN: begin
                    nxt++;
                    if (nxt > hi) begin
                        if (hi <= lo) begin
                            walk_done = 1'b1;
                        end else begin
                            leg = LEG_DOWN;
                            nxt = hi;
                        end
                    end
                end
                LEG_DOWN: begin
                    nxt--;
                    if (nxt < lo) begin
                        leg = LEG_UP;
                        nxt = lo;
                    end
                end
                default: begin
                    nxt++;
                    if (nxt > hi) begin
                        leg = LEG_DOWN;
                        nxt = hi;
                    end
                end
            endcase
            play_pos = LEN_W'(nxt);
            accum = accum + ((pos < MAX_SAMPLES) ? store_mem[pos] : {SAMPLE_W{1'b0}});
            r.sample = accum;
            r.index = pos[INDEX_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : model_track
        if (!i_rst_n) begin
            play_pos = '0;
            leg = LEG_LEAD_IN;
            walk_done = 1'b0;
            accum = '0;
            mdl_cfg = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wlpa_pkg::CFG_BOUNCE_MODE: mdl_cfg.bounce = i_cfg_data[0];
                    wlpa_pkg::CFG_LOOP_ENABLE: mdl_cfg.loop_en = i_cfg_data[0];
                    wlpa_pkg::CFG_LOOP_BEGIN:
                        mdl_cfg.loop_begin = i_cfg_data[INDEX_W-1:0];
                    wlpa_pkg::CFG_LAST_INDEX:
                        mdl_cfg.last_index = i_cfg_data[INDEX_W-1:0];
                    wlpa_pkg::CFG_STORED_LEN:
                        mdl_cfg.stored_length = i_cfg_data[LEN_W-1:0];
                    wlpa_pkg::CFG_SEED:        mdl_cfg.seed = i_cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                accepted_count++;
                case (s_axis_tuser)
                    wlpa_pkg::OP_WRITE: begin
                        store_mem[s_axis_tdata[INDEX_W-1:0]] =
                            s_axis_tdata[INDEX_W+SAMPLE_W-1:INDEX_W];
                    end
                    wlpa_pkg::OP_ADVANCE: begin
                        if (mdl_cfg.bounce) walk_count++;
                        sample_q.insert(sample_q.size(), play_step());
                    end
                    wlpa_pkg::OP_RESTART: begin
                        play_pos = '0;
                        leg = LEG_LEAD_IN;
                        walk_done = 1'b0;
                        accum = mdl_cfg.seed;
                    end
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_play_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.sample = m_axis_tdata[SAMPLE_W-1:0];
            got.index = m_axis_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W];
            got.finished = m_axis_tuser;
            if (sample_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("mismatch: unexpected result sample %h index %0d finished %0b",
                             got.sample, got.index, got.finished);
                end
            end else begin
                want = sample_q.pop_front();
                checked_count++;
                if (got.sample !== want.sample || got.index !== want.index ||
                        got.finished !== want.finished) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp sample %h index %0d finished %0b, got %h %0d %0b",
                                 want.sample, want.index, want.finished,
                                 got.sample, got.index, got.finished);
                    end
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [INDEX_W-1:0] addr,
                             input logic [SAMPLE_W-1:0] word);
        while (!steady && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(S_TDATA_W-INDEX_W-SAMPLE_W){1'b0}}, word, addr};
        s_axis_tuser <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic advance(input int n);
        repeat (n) send_item(wlpa_pkg::OP_ADVANCE, INDEX_W'($urandom), $urandom);
    endtask

    task automatic restart_play();
        send_item(wlpa_pkg::OP_RESTART, INDEX_W'($urandom), $urandom);
    endtask

    // hold off the sender until every result is in and the pipe is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        reg_update_count++;
    endtask

    task automatic write_regs(input wlpa_pkg::t_cfg c, input logic [5:0] mask);
        if (mask[wlpa_pkg::CFG_BOUNCE_MODE]) begin
            write_reg(wlpa_pkg::CFG_BOUNCE_MODE, CFG_DATA_W'(c.bounce));
        end
        if (mask[wlpa_pkg::CFG_LOOP_ENABLE]) begin
            write_reg(wlpa_pkg::CFG_LOOP_ENABLE, CFG_DATA_W'(c.loop_en));
        end
        if (mask[wlpa_pkg::CFG_LOOP_BEGIN]) begin
            write_reg(wlpa_pkg::CFG_LOOP_BEGIN, CFG_DATA_W'(c.loop_begin));
        end
        if (mask[wlpa_pkg::CFG_LAST_INDEX]) begin
            write_reg(wlpa_pkg::CFG_LAST_INDEX, CFG_DATA_W'(c.last_index));
        end
        if (mask[wlpa_pkg::CFG_STORED_LEN]) begin
            write_reg(wlpa_pkg::CFG_STORED_LEN, CFG_DATA_W'(c.stored_length));
        end
        if (mask[wlpa_pkg::CFG_SEED]) begin
            write_reg(wlpa_pkg::CFG_SEED, CFG_DATA_W'(c.seed));
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic wlpa_pkg::t_cfg make_cfg(input logic pp, input logic le, input int lo,
                                                input int hi, input int len,
                                                input logic [SAMPLE_W-1:0] seed);
        wlpa_pkg::t_cfg c;
        c.bounce = pp;
        c.loop_en = le;
        c.loop_begin = INDEX_W'(lo);
        c.last_index = INDEX_W'(hi);
        c.stored_length = LEN_W'(len);
        c.seed = seed;
        return c;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_index();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return MAX_SAMPLES - 1;
            2: return FILL_N - 1;
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    function automatic wlpa_pkg::t_cfg rand_cfg();
        int len;
        case ($urandom_range(0, 4))
            0: len = 0;
            1: len = MAX_SAMPLES;
            2: len = $urandom_range(0, MAX_SAMPLES);
            default: len = $urandom_range(0, 40);
        endcase
        return make_cfg(1'($urandom), 1'($urandom), pick_index(), pick_index(), len,
                        pick_word());
    endfunction

    // low window and top entry get written before any playback reads them
    task automatic test_fill_store();
        logic [SAMPLE_W-1:0] w;
        for (int a = 0; a < FILL_N; a++) begin
            case (a)
                0: w = 32'h8000_0000;
                1: w = '0;
                2: w = 32'hFFFF_FFFF;
                default: w = $urandom;
            endcase
            send_item(wlpa_pkg::OP_WRITE, INDEX_W'(a), w);
        end
        send_item(wlpa_pkg::OP_WRITE, INDEX_W'(MAX_SAMPLES - 1), 32'h7FFF_FFFF);
    endtask

    task automatic test_forward();
        settle();
        write_regs(make_cfg(1'b0, 1'b0, 0, 3, 4, '0), ALL_REGS);
        restart_play();
        advance(6);
        send_item(OP_UNUSED, INDEX_W'($urandom), $urandom);
        advance(1);
        settle();
        write_regs(make_cfg(1'b0, 1'b1, 2, 4, MAX_SAMPLES, '0), 6'b011110);
        restart_play();
        advance(7);
        // loop start above loop end: the loop start entry repeats
        settle();
        write_regs(make_cfg(1'b0, 1'b1, 5, 2, MAX_SAMPLES, '0), 6'b001100);
        restart_play();
        advance(5);
    endtask

    task automatic test_saturation();
        settle();
        write_regs(make_cfg(1'b0, 1'b1, MAX_SAMPLES - 2, 0, 0, 32'h0000_1234), ALL_REGS);
        restart_play();
        advance(1);
        settle();
        write_regs(make_cfg(1'b0, 1'b0, 0, 0, 0, '0), 6'b000010);
        advance(4);
        // switch to ping-pong with the position parked past the store
        settle();
        write_regs(make_cfg(1'b1, 1'b0, 0, 10, 0, '0), 6'b001101);
        advance(3);
    endtask

    task automatic test_walk();
        settle();
        write_regs(make_cfg(1'b1, 1'b0, 1, 3, 0, 32'h7FFF_FFFF), ALL_REGS);
        restart_play();
        advance(12);
        // empty loop: walk ends after the lead-in
        settle();
        write_regs(make_cfg(1'b1, 1'b0, 2, 2, 0, 32'h8000_0000), 6'b101100);
        restart_play();
        advance(5);
        restart_play();
        advance(1);
    endtask

    task automatic test_extremes();
        settle();
        write_regs(make_cfg(1'b0, 1'b1, MAX_SAMPLES - 1, 0, MAX_SAMPLES, '0), ALL_REGS);
        restart_play();
        advance(3);
        settle();
        write_regs(make_cfg(1'b1, 1'b0, MAX_SAMPLES - 1, MAX_SAMPLES - 1, MAX_SAMPLES,
                            '0), 6'b001011);
        restart_play();
        advance(3);
    endtask

    task automatic test_random_play(input int n_items, input bit quiet);
        int sent;
        int roll;
        steady = quiet;
        sent = 0;
        while (sent < n_items) begin
            settle();
            write_regs(rand_cfg(), ($urandom_range(0, 3) == 0) ? ALL_REGS : 6'($urandom));
            if ($urandom_range(0, 4) != 0) begin
                restart_play();
                sent++;
            end
            repeat ($urandom_range(20, 150)) begin
                roll = $urandom_range(0, 99);
                if (roll < 68) begin
                    // rewind before the position leaves the written part of the store
                    if (play_pos >= LEN_W'(FILL_N - 1) && play_pos < LEN_W'(MAX_SAMPLES)) begin
                        restart_play();
                    end else begin
                        advance(1);
                    end
                    sent++;
                end else if (roll < 86) begin
                    send_item(wlpa_pkg::OP_WRITE, ($urandom_range(0, 1) != 0) ?
                              INDEX_W'($urandom_range(0, 40)) : INDEX_W'($urandom),
                              pick_word());
                    sent++;
                end else if (roll < 93) begin
                    restart_play();
                    sent++;
                end else if (roll < 98) begin
                    send_item(OP_UNUSED, INDEX_W'($urandom), $urandom);
                end else begin
                    settle();
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_fill_store();
        test_forward();
        test_saturation();
        test_walk();
        test_extremes();
        test_random_play(550, 1'b0);
        test_random_play(250, 1'b1);
        test_random_play(550, 1'b0);
        settle();
        repeat (8) @(posedge i_clk);
        $display("run: %0d transactions accepted, %0d samples checked (%0d ping-pong)",
                 accepted_count, checked_count, walk_count);
        $display("run: %0d register writes, %0d mismatches", reg_update_count, mismatch_count);
        if (mismatch_count == 0 && sample_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
